FILE: hw/rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer with overwrite and peek.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int unsigned DEPTH_DEF = 4096;

  localparam int unsigned CAP_W   = 12;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned TALLY_W = 13;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET = 12'd4095;
  localparam logic [CAP_W-1:0]   CAP_MAX   = 12'd4095;
  localparam logic [TALLY_W-1:0] TALLY_MAX = 13'h1FFF;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // operation codes on the kind port
  localparam logic [KIND_W-1:0] KIND_PUSH  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FPUSH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SKIP  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 3'd5;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_FPUSH,
    OP_POP,
    OP_PEEK,
    OP_SKIP,
    OP_FLUSH,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] din;
    logic [CAP_W-1:0]  off;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic             flush;
    logic [CAP_W-1:0] cap;
  } cfg_t;

endpackage

FILE: hw/rtl/brb_front.sv
// ----------------------------------------------------------------------------
// brb_front
// Accepts commands and decodes the kind code into an internal operation.
// ----------------------------------------------------------------------------
module brb_front (
  input  logic                       start,
  input  logic                       full,
  input  logic [brb_pkg::KIND_W-1:0] kind,
  input  logic [brb_pkg::BYTE_W-1:0] data_in,
  input  logic [brb_pkg::CAP_W-1:0]  offset,
  input  logic                       burst_last,
  output logic                       push,
  output brb_pkg::cmd_t              cmd
);
  import brb_pkg::*;

  op_t op;

  always_comb begin
    unique case (kind)
      KIND_PUSH:  op = OP_PUSH;
      KIND_FPUSH: op = OP_FPUSH;
      KIND_POP:   op = OP_POP;
      KIND_PEEK:  op = OP_PEEK;
      KIND_SKIP:  op = OP_SKIP;
      KIND_FLUSH: op = OP_FLUSH;
      default:    op = OP_NOP;
    endcase
  end

  assign push     = start & ~full;
  assign cmd.op   = op;
  assign cmd.din  = data_in;
  assign cmd.off  = offset;
  assign cmd.last = burst_last;

endmodule

FILE: hw/rtl/brb_queue.sv
// ----------------------------------------------------------------------------
// brb_queue
// Two-entry command queue between the decoder and the execution side.
// ----------------------------------------------------------------------------
module brb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  brb_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output brb_pkg::cmd_t rd_cmd,
  output logic          not_empty,
  output logic          full
);
  import brb_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_cmd;
  end

  assign rd_cmd    = slots[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = count[1];

endmodule

FILE: hw/rtl/brb_back.sv
// ----------------------------------------------------------------------------
// brb_back
// Executes ring operations: positions, fill level, burst tally and byte store.
// ----------------------------------------------------------------------------
module brb_back #(
  parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  brb_pkg::cfg_t               cfg,
  input  brb_pkg::cmd_t               cmd,
  input  logic                        take,
  output logic                        valid,
  output logic [brb_pkg::BYTE_W-1:0]  data_out,
  output logic                        ok,
  output logic [brb_pkg::CAP_W-1:0]   level,
  output logic [brb_pkg::CAP_W-1:0]   free_space,
  output logic [brb_pkg::TALLY_W-1:0] burst_count
);
  import brb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [BYTE_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0]   wp, rp, lvl;
  logic [TALLY_W-1:0] tally;

  logic [CAP_W-1:0]   wp_next, rp_next, lvl_next;
  logic [TALLY_W-1:0] tally_res, tally_bump;
  logic [CAP_W:0]     len, adv_sum;
  logic [CAP_W-1:0]   wp_inc, rp_inc, skip_n, adv_n, adv_pos, rd_addr;
  logic               ok_n, bump, wr_en, rd_en;

  logic [BYTE_W-1:0]  rd_q;
  logic               rd_flag;

  always_comb begin
    len     = {1'b0, cfg.cap} + {{CAP_W{1'b0}}, 1'b1};
    wp_inc  = (wp == cfg.cap) ? '0 : wp + 12'd1;
    rp_inc  = (rp == cfg.cap) ? '0 : rp + 12'd1;
    skip_n  = (cmd.off <= lvl) ? cmd.off : lvl;
    adv_n   = (cmd.op == OP_PEEK) ? cmd.off : skip_n;
    adv_sum = {1'b0, rp} + {1'b0, adv_n};
    // sum stays below twice the ring length for every offset that is used
    adv_pos = (adv_sum >= len) ? CAP_W'(adv_sum - len) : adv_sum[CAP_W-1:0];
    tally_bump = (tally == TALLY_MAX) ? tally : tally + 13'd1;

    wp_next  = wp;
    rp_next  = rp;
    lvl_next = lvl;
    ok_n     = 1'b0;
    bump     = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = rp;

    unique case (cmd.op)
      OP_PUSH: begin
        if (lvl < cfg.cap) begin
          wr_en    = 1'b1;
          wp_next  = wp_inc;
          lvl_next = lvl + 12'd1;
          ok_n     = 1'b1;
          bump     = 1'b1;
        end
      end
      OP_FPUSH: begin
        wr_en   = 1'b1;
        wp_next = wp_inc;
        // full ring: oldest byte is dropped, level holds
        if (lvl >= cfg.cap) rp_next = rp_inc;
        else                lvl_next = lvl + 12'd1;
        ok_n = 1'b1;
        bump = 1'b1;
      end
      OP_POP: begin
        if (lvl != '0) begin
          rd_en    = 1'b1;
          rp_next  = rp_inc;
          lvl_next = lvl - 12'd1;
          ok_n     = 1'b1;
          bump     = 1'b1;
        end
      end
      OP_PEEK: begin
        if (cmd.off < lvl) begin
          rd_en   = 1'b1;
          rd_addr = adv_pos;
          ok_n    = 1'b1;
          bump    = 1'b1;
        end
      end
      OP_SKIP: begin
        rp_next  = adv_pos;
        lvl_next = lvl - skip_n;
        ok_n     = (cmd.off <= lvl);
      end
      OP_FLUSH: begin
        wp_next  = '0;
        rp_next  = '0;
        lvl_next = '0;
        ok_n     = 1'b1;
      end
      OP_NOP: begin
        ok_n = 1'b0;
      end
    endcase

    tally_res = bump ? tally_bump : tally;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      lvl   <= '0;
      tally <= '0;
      valid <= 1'b0;
    end else if (cfg.flush) begin
      wp    <= '0;
      rp    <= '0;
      lvl   <= '0;
      valid <= 1'b0;
    end else begin
      valid <= take;
      if (take) begin
        wp    <= wp_next;
        rp    <= rp_next;
        lvl   <= lvl_next;
        tally <= cmd.last ? '0 : tally_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ok          <= ok_n;
      level       <= lvl_next;
      free_space  <= cfg.cap - lvl_next;
      burst_count <= tally_res;
      rd_flag     <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (take && wr_en) mem[AW'(wp)] <= cmd.din;
    if (take && rd_en) rd_q <= mem[AW'(rd_addr)];
  end

  assign data_out = rd_flag ? rd_q : '0;

endmodule

FILE: hw/rtl/byte_ring_buffer_overwrite_peek.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_overwrite_peek
// Byte FIFO on a ring with one empty slot; push, forced push, pop, peek,
// skip and flush commands, one result per command.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; one command per
// clock is sustained. Its result shows on the result ports, flagged by valid
// for one cycle, once the command has left the command queue: the ring
// update, the byte store read and the result registers then all load on the
// same edge. The receiver cannot stall, so results must be taken as they come.
// Writing the capacity register flushes the ring; write it only while no
// command is in flight.
module byte_ring_buffer_overwrite_peek #(
  parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [brb_pkg::KIND_W-1:0]   kind,
  input  logic [brb_pkg::BYTE_W-1:0]   data_in,
  input  logic [brb_pkg::CAP_W-1:0]    offset,
  input  logic                         burst_last,
  output logic                         valid,
  output logic [brb_pkg::BYTE_W-1:0]   data_out,
  output logic                         ok,
  output logic [brb_pkg::CAP_W-1:0]    level,
  output logic [brb_pkg::CAP_W-1:0]    free_space,
  output logic [brb_pkg::TALLY_W-1:0]  burst_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [brb_pkg::PADDR_W-1:0]  paddr,
  input  logic [brb_pkg::PDATA_W-1:0]  pwdata,
  output logic [brb_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import brb_pkg::*;

  localparam logic [CAP_W-1:0] CapLim =
    CAP_W'((DEPTH - 1 > 4095) ? 4095 : DEPTH - 1);

  logic [CAP_W-1:0] cap_raw;
  logic [CAP_W-1:0] cap_eff;
  logic [CAP_W-1:0] cap_clamp;
  logic             cfg_wr;
  cfg_t             cfg;

  cmd_t f_cmd, q_cmd;
  logic f_push, q_pop, q_not_empty, q_full;

  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_CAPACITY);

  always_comb begin
    cap_clamp = pwdata[CAP_W-1:0];
    if (cap_clamp == '0)    cap_clamp = 12'd1;
    if (cap_clamp > CapLim) cap_clamp = CapLim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_raw <= CAP_RESET;
      cap_eff <= (CAP_MAX > CapLim) ? CapLim : CAP_MAX;
    end else if (cfg_wr) begin
      cap_raw <= pwdata[CAP_W-1:0];
      cap_eff <= cap_clamp;
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(PDATA_W-CAP_W){1'b0}}, cap_raw} : '0;

  assign cfg.flush = cfg_wr;
  assign cfg.cap   = cap_eff;

  brb_front u_front (
    .start      (start),
    .full       (q_full),
    .kind       (kind),
    .data_in    (data_in),
    .offset     (offset),
    .burst_last (burst_last),
    .push       (f_push),
    .cmd        (f_cmd)
  );

  brb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .wr_cmd    (f_cmd),
    .pop       (q_pop),
    .rd_cmd    (q_cmd),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  assign q_pop = q_not_empty;
  assign busy  = q_full;

  brb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (q_cmd),
    .take        (q_pop),
    .valid       (valid),
    .data_out    (data_out),
    .ok          (ok),
    .level       (level),
    .free_space  (free_space),
    .burst_count (burst_count)
  );

`ifndef SYNTHESIS
  a_level_plus_free: assert property (@(posedge clk) disable iff (rst)
    valid |-> ({1'b0, level} + {1'b0, free_space} == {1'b0, cap_eff}))
    else $error("level and free space do not add up to capacity");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    valid |-> (level <= cap_eff))
    else $error("fill level above capacity");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(q_pop))
    else $error("result strobe without a dequeued command");
`endif

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte ring buffer with overwrite and peek.
// Commands go in on the start/busy handshake and capacity is set over APB.
// Results not given in the directed table come from a behavioral ring model;
// each result transfer is compared field by field. Stimulus: directed table,
// then random phases at several capacities. The sender idles at random.
// ----------------------------------------------------------------------------
module tb;
  import brb_pkg::*;

  localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;
  localparam logic [PADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic [BYTE_W-1:0]  data_out;
    logic               ok;
    logic [CAP_W-1:0]   level;
    logic [CAP_W-1:0]   free_space;
    logic [TALLY_W-1:0] burst_count;
  } ring_result_t;

  // is_cfg rows write arg into the capacity register
  typedef struct packed {
    logic              is_cfg;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] din;
    logic [CAP_W-1:0]  arg;
    logic              last;
    logic              typed;
    ring_result_t      want;
  } dir_row_t;

  localparam ring_result_t ZERO_REPLY = '0;
  localparam int DIR_N = 29;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // straight out of reset, capacity 4095
    '{1'b0, KIND_POP,     8'h00, 12'd0,    1'b0, 1'b1, '{8'h00, 1'b0, 12'd0, 12'd4095, 13'd0}},
    '{1'b0, KIND_PEEK,    8'h00, 12'd4095, 1'b0, 1'b1, '{8'h00, 1'b0, 12'd0, 12'd4095, 13'd0}},
    '{1'b0, KIND_PUSH,    8'hFF, 12'd0,    1'b0, 1'b1, '{8'h00, 1'b1, 12'd1, 12'd4094, 13'd1}},
    '{1'b0, KIND_PUSH,    8'h00, 12'd0,    1'b1, 1'b1, '{8'h00, 1'b1, 12'd2, 12'd4093, 13'd2}},
    '{1'b0, KIND_PEEK,    8'h00, 12'd1,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_SKIP,    8'h00, 12'd4095, 1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_RSVD_LO, 8'h55, 12'd0,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_RSVD_HI, 8'hAA, 12'd4095, 1'b1, 1'b0, ZERO_REPLY},
    // capacity zero behaves as one
    '{1'b1, KIND_PUSH,    8'h00, 12'd0,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_PUSH,    8'hA5, 12'd0,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_PUSH,    8'h5A, 12'd0,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_FPUSH,   8'h3C, 12'd0,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_POP,     8'h00, 12'd0,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_POP,     8'h00, 12'd0,    1'b1, 1'b0, ZERO_REPLY},
    // capacity 3: overwrite, refused push, peek and skip edges, flush
    '{1'b1, KIND_PUSH,    8'h00, 12'd3,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_FPUSH,   8'h01, 12'd0,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_FPUSH,   8'h02, 12'd0,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_FPUSH,   8'h03, 12'd0,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_FPUSH,   8'h04, 12'd0,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_PUSH,    8'h80, 12'd0,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_PEEK,    8'h00, 12'd2,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_PEEK,    8'h00, 12'd3,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_SKIP,    8'h00, 12'd0,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_SKIP,    8'h00, 12'd1,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_FLUSH,   8'h00, 12'd0,    1'b1, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_SKIP,    8'h00, 12'd2,    1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_POP,     8'h00, 12'd0,    1'b0, 1'b0, ZERO_REPLY},
    // back to full size
    '{1'b1, KIND_PUSH,    8'h00, 12'd4095, 1'b0, 1'b0, ZERO_REPLY},
    '{1'b0, KIND_PUSH,    8'h7E, 12'd0,    1'b1, 1'b0, ZERO_REPLY}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [KIND_W-1:0] kind = KIND_PUSH;
  logic [BYTE_W-1:0] data_in = '0;
  logic [CAP_W-1:0] offset = '0;
  logic burst_last = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;

  logic busy;
  logic valid;
  logic [BYTE_W-1:0] data_out;
  logic ok;
  logic [CAP_W-1:0] level;
  logic [CAP_W-1:0] free_space;
  logic [TALLY_W-1:0] burst_count;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  always #10 clk = ~clk;

  byte_ring_buffer_overwrite_peek dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .data_in(data_in), .offset(offset), .burst_last(burst_last),
    .valid(valid), .data_out(data_out), .ok(ok), .level(level),
    .free_space(free_space), .burst_count(burst_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // ring model state
  logic [BYTE_W-1:0] ring_mem [0:DEPTH_DEF-1];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;
  int unsigned tally = 0;
  int unsigned cap_raw = CAP_RESET;

  ring_result_t ring_replies [$];
  ring_result_t mon_want;
  int mismatch_count = 0;

  function automatic int unsigned cap_eff();
    int unsigned c;
    c = cap_raw & 32'hFFF;
    if (c < 1) c = 1;
    if (c > CAP_MAX) c = CAP_MAX;
    if (c > DEPTH_DEF - 1) c = DEPTH_DEF - 1;
    return c;
  endfunction

  function automatic int unsigned ring_adv(input int unsigned pos, input int unsigned n);
    int unsigned len;
    int unsigned p;
    len = cap_eff() + 1;
    p = pos + n;
    while (p >= len) p -= len;
    return p;
  endfunction

  function automatic int unsigned ring_fill();
    if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
    return wr_ptr + cap_eff() + 1 - rd_ptr;
  endfunction

  function automatic void tally_bump();
    if (tally < TALLY_MAX) tally++;
  endfunction

  // applies one command to the model and returns the result it owes
  function automatic ring_result_t ring_op(input logic [KIND_W-1:0] k,
                                           input logic [BYTE_W-1:0] d,
                                           input logic [CAP_W-1:0] o,
                                           input logic l);
    ring_result_t r;
    int unsigned c;
    int unsigned lv;
    r = '0;
    c = cap_eff();
    lv = ring_fill();
    case (k)
      KIND_PUSH: begin
        if (lv < c) begin
          ring_mem[wr_ptr] = d;
          wr_ptr = ring_adv(wr_ptr, 1);
          r.ok = 1'b1;
          tally_bump();
        end
      end
      KIND_FPUSH: begin
        ring_mem[wr_ptr] = d;
        wr_ptr = ring_adv(wr_ptr, 1);
        if (lv >= c) rd_ptr = ring_adv(rd_ptr, 1);
        r.ok = 1'b1;
        tally_bump();
      end
      KIND_POP: begin
        if (lv > 0) begin
          r.data_out = ring_mem[rd_ptr];
          rd_ptr = ring_adv(rd_ptr, 1);
          r.ok = 1'b1;
          tally_bump();
        end
      end
      KIND_PEEK: begin
        if (o < lv) begin
          r.data_out = ring_mem[ring_adv(rd_ptr, o)];
          r.ok = 1'b1;
          tally_bump();
        end
      end
      KIND_SKIP: begin
        if (o <= lv) begin
          rd_ptr = ring_adv(rd_ptr, o);
          r.ok = 1'b1;
        end else begin
          rd_ptr = ring_adv(rd_ptr, lv);
        end
      end
      KIND_FLUSH: begin
        wr_ptr = 0;
        rd_ptr = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    lv = ring_fill();
    r.level = lv[CAP_W-1:0];
    c = c - lv;
    r.free_space = c[CAP_W-1:0];
    r.burst_count = tally[TALLY_W-1:0];
    if (l) tally = 0;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // result transfers: one per strobe, checked against the oldest owed result
  always @(posedge clk) begin
    if (!rst && valid) begin
      if (ring_replies.size() == 0) begin
        flag_mismatch("result with no command outstanding");
      end else begin
        mon_want = ring_replies.pop_front();
        if (data_out !== mon_want.data_out)
          flag_mismatch($sformatf("data_out %0h, want %0h", data_out, mon_want.data_out));
        if (ok !== mon_want.ok)
          flag_mismatch($sformatf("ok %0b, want %0b", ok, mon_want.ok));
        if (level !== mon_want.level)
          flag_mismatch($sformatf("level %0d, want %0d", level, mon_want.level));
        if (free_space !== mon_want.free_space)
          flag_mismatch($sformatf("free_space %0d, want %0d", free_space,
                                  mon_want.free_space));
        if (burst_count !== mon_want.burst_count)
          flag_mismatch($sformatf("burst_count %0d, want %0d", burst_count,
                                  mon_want.burst_count));
      end
    end
  end

  // called on a rising edge; returns on the edge that completes the transfer
  task automatic apb_xfer(input logic wr, input logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= CAP_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait for all owed results, write capacity, read it back
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    logic [PDATA_W-1:0] rd;
    start <= 1'b0;
    while (ring_replies.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    apb_xfer(1'b1, {{(PDATA_W-CAP_W){1'b0}}, cap}, rd);
    cap_raw = cap;
    wr_ptr = 0;
    rd_ptr = 0;
    @(posedge clk);
    apb_xfer(1'b0, '0, rd);
    if (rd[CAP_W-1:0] !== cap)
      flag_mismatch($sformatf("capacity reads %0d, wrote %0d", rd[CAP_W-1:0], cap));
  endtask

  // holds the command until the transfer, then books its result
  task automatic issue(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] d,
                       input logic [CAP_W-1:0] o, input logic l,
                       input logic typed, input ring_result_t want);
    ring_result_t r;
    start <= 1'b1;
    kind <= k;
    data_in <= d;
    offset <= o;
    burst_last <= l;
    do @(posedge clk); while (busy !== 1'b0);
    r = ring_op(k, d, o, l);
    ring_replies.push_back(typed ? want : r);
  endtask

  task automatic sender_gap(input int idle_pct);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic random_phase(input logic [CAP_W-1:0] cap, input int n_items,
                              input int idle_pct);
    int unsigned lv;
    int unsigned pick;
    logic [KIND_W-1:0] k;
    logic [CAP_W-1:0] o;
    set_capacity(cap);
    for (int i = 0; i < n_items; i++) begin
      lv = ring_fill();
      pick = $urandom_range(0, 99);
      o = 12'($urandom_range(0, 4095));
      if (pick < 30) begin
        k = KIND_PUSH;
      end else if (pick < 45) begin
        k = KIND_FPUSH;
      end else if (pick < 70) begin
        k = KIND_POP;
      end else if (pick < 85) begin
        k = KIND_PEEK;
        if ($urandom_range(0, 4) != 0) o = 12'($urandom_range(0, lv + 1));
      end else if (pick < 95) begin
        k = KIND_SKIP;
        if ($urandom_range(0, 5) != 0) o = 12'($urandom_range(0, lv + 1));
      end else if (pick < 98) begin
        k = KIND_FLUSH;
      end else begin
        k = $urandom_range(0, 1) ? KIND_RSVD_HI : KIND_RSVD_LO;
      end
      issue(k, 8'($urandom_range(0, 255)), o, $urandom_range(0, 7) == 0, 1'b0, ZERO_REPLY);
      sender_gap(idle_pct);
    end
  endtask

  logic [CAP_W-1:0] phase_caps [8];

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].is_cfg) begin
        set_capacity(DIR_TAB[i].arg);
      end else begin
        issue(DIR_TAB[i].kind, DIR_TAB[i].din, DIR_TAB[i].arg, DIR_TAB[i].last,
              DIR_TAB[i].typed, DIR_TAB[i].want);
        sender_gap(25);
      end
    end

    phase_caps = '{12'd1, 12'd5, 12'd0, 12'd16, 12'd4095, 12'd3,
                   12'($urandom_range(2, 40)), 12'($urandom_range(0, 4095))};
    for (int ph = 0; ph < 8; ph++) begin
      // last phase runs flat out
      random_phase(phase_caps[ph], 110, (ph == 7) ? 0 : (ph % 3) * 20);
    end

    start <= 1'b0;
    while (ring_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/brb_pkg.sv
hw/rtl/brb_front.sv
hw/rtl/brb_queue.sv
hw/rtl/brb_back.sv
hw/rtl/byte_ring_buffer_overwrite_peek.sv
sim/tb.sv
